// File: rtl/core/max_pool_stream_defines.svh
// Assertion macros used by the checker file.
`ifndef MAX_POOL_STREAM_DEFINES_SVH
`define MAX_POOL_STREAM_DEFINES_SVH

// same-cycle implication, off while reset is low
`define MPS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is low
`define MPS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/mps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mps_pkg;

  localparam int MAX_WIDTH    = 256;
  localparam int MAX_POOL     = 8;
  localparam int SAMPLE_BITS  = 16;
  localparam int MAX_CHANNELS = 1024;

  localparam int POOL_W     = 4;
  localparam int DIM_W      = 9;
  localparam int CHN_W      = 11;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;

  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int WIN_W    = $clog2(MAX_POOL);
  localparam int CHAN_W   = $clog2(MAX_CHANNELS);
  localparam int POOLED_W = SAMPLE_BITS - 1;

  localparam int IN_DATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_FLD_W  = POOLED_W + 2 * COL_W + CHAN_W;
  localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - OUT_FLD_W;

  localparam logic [POOL_W-1:0] POOL_RESET   = POOL_W'(2);
  localparam logic [DIM_W-1:0]  WIDTH_RESET  = DIM_W'(28);
  localparam logic [DIM_W-1:0]  HEIGHT_RESET = DIM_W'(28);
  localparam logic [CHN_W-1:0]  CHAN_RESET   = CHN_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POOL_SIZE     = 2'd0,
    REG_IN_WIDTH      = 2'd1,
    REG_IN_HEIGHT     = 2'd2,
    REG_CHANNEL_COUNT = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [POOL_W-1:0] pool_size;
    logic [DIM_W-1:0]  in_width;
    logic [DIM_W-1:0]  in_height;
    logic [CHN_W-1:0]  channel_count;
  } cfg_t;

  typedef struct packed {
    logic              first;
    logic              win_last;
    logic              in_window;
    logic              frame_last;
    logic [COL_W-1:0]  oc;
    logic [COL_W-1:0]  orow;
    logic [CHAN_W-1:0] chan;
  } pos_t;

endpackage
`default_nettype wire

// File: rtl/core/mps_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
module mps_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr_en,
  input  wire logic [mps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mps_pkg::CFG_DATA_W-1:0] cfg_wr_data,
  output mps_pkg::cfg_t                       cfg,
  output logic                                restart
);
  import mps_pkg::*;

  cfg_t              cfg_r, cfg_nxt;
  logic [POOL_W-1:0] pool_raw, pool_val;
  logic [DIM_W-1:0]  dim_raw, dim_val;
  logic [CHN_W-1:0]  chn_raw, chn_val;

  always_comb begin
    pool_raw = cfg_wr_data[POOL_W-1:0];
    dim_raw  = cfg_wr_data[DIM_W-1:0];
    chn_raw  = cfg_wr_data[CHN_W-1:0];

    if (pool_raw == '0) pool_val = POOL_W'(1);
    else if (pool_raw > POOL_W'(MAX_POOL)) pool_val = POOL_W'(MAX_POOL);
    else pool_val = pool_raw;

    if (dim_raw == '0) dim_val = DIM_W'(1);
    else if (dim_raw > DIM_W'(MAX_WIDTH)) dim_val = DIM_W'(MAX_WIDTH);
    else dim_val = dim_raw;

    if (chn_raw == '0) chn_val = CHN_W'(1);
    else if (chn_raw > CHN_W'(MAX_CHANNELS)) chn_val = CHN_W'(MAX_CHANNELS);
    else chn_val = chn_raw;
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_POOL_SIZE:     cfg_nxt.pool_size     = pool_val;
        REG_IN_WIDTH:      cfg_nxt.in_width      = dim_val;
        REG_IN_HEIGHT:     cfg_nxt.in_height     = dim_val;
        REG_CHANNEL_COUNT: cfg_nxt.channel_count = chn_val;
        default:           cfg_nxt               = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pool_size     <= POOL_RESET;
      cfg_r.in_width      <= WIDTH_RESET;
      cfg_r.in_height     <= HEIGHT_RESET;
      cfg_r.channel_count <= CHAN_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg     = cfg_r;
  assign restart = cfg_wr_en;

endmodule
`default_nettype wire

// File: rtl/core/mps_pos.sv
`timescale 1ns / 1ps
`default_nettype none
module mps_pos (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire mps_pkg::cfg_t cfg,
  input  wire logic          restart,
  input  wire logic          advance,
  output mps_pkg::pos_t      pos
);
  import mps_pkg::*;

  logic [COL_W-1:0]  col_r, col_nxt;
  logic [WIN_W-1:0]  cw_r, cw_nxt;
  logic [COL_W-1:0]  ws_r, ws_nxt;
  logic [COL_W-1:0]  oc_r, oc_nxt;
  logic [COL_W-1:0]  row_r, row_nxt;
  logic [WIN_W-1:0]  rw_r, rw_nxt;
  logic [COL_W-1:0]  rs_r, rs_nxt;
  logic [COL_W-1:0]  orow_r, orow_nxt;
  logic [CHAN_W-1:0] ch_r, ch_nxt;

  logic cw_wrap, rw_wrap, col_wrap, row_wrap, ch_wrap;
  logic col_ok, row_ok, col_last, row_last;
  logic [DIM_W:0] ws_end, rs_end, ws_end2, rs_end2;

  always_comb begin
    cw_wrap  = (POOL_W'({1'b0, cw_r}) + POOL_W'(1)) >= cfg.pool_size;
    rw_wrap  = (POOL_W'({1'b0, rw_r}) + POOL_W'(1)) >= cfg.pool_size;
    col_wrap = (DIM_W'({1'b0, col_r}) + DIM_W'(1)) >= cfg.in_width;
    row_wrap = (DIM_W'({1'b0, row_r}) + DIM_W'(1)) >= cfg.in_height;
    ch_wrap  = (CHN_W'({1'b0, ch_r}) + CHN_W'(1)) >= cfg.channel_count;

    // window end positions replace the divide by pool_size
    ws_end  = (DIM_W + 1)'(ws_r) + (DIM_W + 1)'(cfg.pool_size);
    rs_end  = (DIM_W + 1)'(rs_r) + (DIM_W + 1)'(cfg.pool_size);
    ws_end2 = ws_end + (DIM_W + 1)'(cfg.pool_size);
    rs_end2 = rs_end + (DIM_W + 1)'(cfg.pool_size);
    col_ok   = ws_end <= (DIM_W + 1)'(cfg.in_width);
    row_ok   = rs_end <= (DIM_W + 1)'(cfg.in_height);
    col_last = ws_end2 > (DIM_W + 1)'(cfg.in_width);
    row_last = rs_end2 > (DIM_W + 1)'(cfg.in_height);
  end

  always_comb begin
    col_nxt  = col_r;
    cw_nxt   = cw_r;
    ws_nxt   = ws_r;
    oc_nxt   = oc_r;
    row_nxt  = row_r;
    rw_nxt   = rw_r;
    rs_nxt   = rs_r;
    orow_nxt = orow_r;
    ch_nxt   = ch_r;
    priority if (restart) begin
      col_nxt  = '0;
      cw_nxt   = '0;
      ws_nxt   = '0;
      oc_nxt   = '0;
      row_nxt  = '0;
      rw_nxt   = '0;
      rs_nxt   = '0;
      orow_nxt = '0;
      ch_nxt   = '0;
    end else if (advance) begin
      if (col_wrap) begin
        col_nxt = '0;
        cw_nxt  = '0;
        ws_nxt  = '0;
        oc_nxt  = '0;
        if (row_wrap) begin
          row_nxt  = '0;
          rw_nxt   = '0;
          rs_nxt   = '0;
          orow_nxt = '0;
          ch_nxt   = ch_wrap ? '0 : ch_r + CHAN_W'(1);
        end else begin
          row_nxt = row_r + COL_W'(1);
          if (rw_wrap) begin
            rw_nxt   = '0;
            rs_nxt   = rs_r + COL_W'(cfg.pool_size);
            orow_nxt = orow_r + COL_W'(1);
          end else begin
            rw_nxt = rw_r + WIN_W'(1);
          end
        end
      end else begin
        col_nxt = col_r + COL_W'(1);
        if (cw_wrap) begin
          cw_nxt = '0;
          ws_nxt = ws_r + COL_W'(cfg.pool_size);
          oc_nxt = oc_r + COL_W'(1);
        end else begin
          cw_nxt = cw_r + WIN_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      cw_r   <= '0;
      ws_r   <= '0;
      oc_r   <= '0;
      row_r  <= '0;
      rw_r   <= '0;
      rs_r   <= '0;
      orow_r <= '0;
      ch_r   <= '0;
    end else begin
      col_r  <= col_nxt;
      cw_r   <= cw_nxt;
      ws_r   <= ws_nxt;
      oc_r   <= oc_nxt;
      row_r  <= row_nxt;
      rw_r   <= rw_nxt;
      rs_r   <= rs_nxt;
      orow_r <= orow_nxt;
      ch_r   <= ch_nxt;
    end
  end

  always_comb begin
    pos.first      = (cw_r == '0) && (rw_r == '0);
    pos.win_last   = cw_wrap && rw_wrap;
    pos.in_window  = col_ok && row_ok;
    pos.frame_last = ch_wrap && row_last && col_last;
    pos.oc         = oc_r;
    pos.orow       = orow_r;
    pos.chan       = ch_r;
  end

endmodule
`default_nettype wire

// File: rtl/core/mps_pool.sv
`timescale 1ns / 1ps
`default_nettype none
module mps_pool (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [mps_pkg::SAMPLE_BITS-1:0] in_sample,
  input  wire mps_pkg::pos_t                   pos,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [mps_pkg::POOLED_W-1:0]         out_pooled,
  output logic [mps_pkg::COL_W-1:0]            out_col,
  output logic [mps_pkg::COL_W-1:0]            out_row,
  output logic [mps_pkg::CHAN_W-1:0]           out_chan,
  output logic                                 out_last
);
  import mps_pkg::*;

  logic [POOLED_W-1:0] mem [MAX_WIDTH];

  logic                a_valid_r, a_valid_nxt;
  pos_t                a_pos_r;
  logic [POOLED_W-1:0] a_samp_r;
  logic [POOLED_W-1:0] rd_data_r;
  logic                byp_r;
  logic [POOLED_W-1:0] byp_data_r;

  logic                out_valid_r, out_valid_nxt;
  logic [POOLED_W-1:0] pooled_r;
  logic [COL_W-1:0]    col_r, row_r;
  logic [CHAN_W-1:0]   chan_r;
  logic                last_r;

  logic                in_fire, a_res, a_go, wr_en;
  logic [POOLED_W-1:0] cur, new_max, samp_pos;

  always_comb begin
    samp_pos = in_sample[SAMPLE_BITS-1] ? '0 : in_sample[POOLED_W-1:0];
    a_res    = a_pos_r.in_window && a_pos_r.win_last;
    a_go     = a_valid_r && (!a_res || !out_valid_r || out_ready);
    in_ready = !a_valid_r || a_go;
    in_fire  = in_valid && in_ready;
    cur      = byp_r ? byp_data_r : rd_data_r;
    if (a_pos_r.first) new_max = a_samp_r;
    else if (a_samp_r > cur) new_max = a_samp_r;
    else new_max = cur;
    wr_en = a_go && a_pos_r.in_window;
  end

  // read on accept; forward the write-back when it hits the same column
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[a_pos_r.oc] <= new_max;
    end
    if (in_fire) begin
      rd_data_r  <= mem[pos.oc];
      byp_r      <= wr_en && (a_pos_r.oc == pos.oc);
      byp_data_r <= new_max;
      a_pos_r    <= pos;
      a_samp_r   <= samp_pos;
    end
  end

  always_comb begin
    if (in_fire) a_valid_nxt = 1'b1;
    else if (a_go) a_valid_nxt = 1'b0;
    else a_valid_nxt = a_valid_r;

    if (a_go && a_res) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_valid_r   <= a_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_go && a_res) begin
      pooled_r <= new_max;
      col_r    <= a_pos_r.oc;
      row_r    <= a_pos_r.orow;
      chan_r   <= a_pos_r.chan;
      last_r   <= a_pos_r.frame_last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_pooled = pooled_r;
  assign out_col    = col_r;
  assign out_row    = row_r;
  assign out_chan   = chan_r;
  assign out_last   = last_r;

endmodule
`default_nettype wire

// File: rtl/core/max_pool_stream.sv
`timescale 1ns / 1ps
`default_nettype none
// Streaming 2-D max pooling over non-overlapping pool_size x pool_size windows.
// Samples (signed Q8.8) come in channel, row, column raster order and are
// taken one per clock; a sample is read against the running maximum of its
// output column at accept, and the new maximum is written back from the
// sample stage, forwarding so back-to-back samples of one window never stall.
// A pooled value (floored at zero) is registered after its window's last
// sample; tlast marks the last value of a frame. Input stalls only while a
// finished result sits in the sample stage and the output register is full
// and not taken. The column maxima store needs no clearing after reset.
// Any configuration write restarts the frame; write only while idle.
module max_pool_stream (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // in_tdata: sample[15:0]
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [mps_pkg::IN_DATA_W-1:0]  in_tdata,
  // out_tdata: pooled[14:0], out_col[22:15], out_row[30:23],
  //            out_channel[40:31], zero[47:41]; out_tlast: frame_end
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [mps_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                out_tlast,
  input  wire logic                           cfg_wr_en,
  input  wire logic [mps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mps_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
  import mps_pkg::*;

  cfg_t                cfg;
  pos_t                pos;
  logic                restart;
  logic [POOLED_W-1:0] pooled;
  logic [COL_W-1:0]    ocol, orow;
  logic [CHAN_W-1:0]   ochan;

  mps_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .cfg         (cfg),
    .restart     (restart)
  );

  mps_pos u_pos (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .restart (restart),
    .advance (in_tvalid && in_tready),
    .pos     (pos)
  );

  mps_pool u_pool (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_sample  (in_tdata[SAMPLE_BITS-1:0]),
    .pos        (pos),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_pooled (pooled),
    .out_col    (ocol),
    .out_row    (orow),
    .out_chan   (ochan),
    .out_last   (out_tlast)
  );

  assign out_tdata = {{OUT_PAD_W{1'b0}}, ochan, orow, ocol, pooled};

endmodule
`default_nettype wire

// File: rtl/core/max_pool_stream_chk.sv
`timescale 1ns / 1ps
`default_nettype none
`include "max_pool_stream_defines.svh"
module max_pool_stream_chk (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tready,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [mps_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic                           out_tlast
);

  `MPS_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result request dropped while stalled")

  // input back-pressure only comes from a blocked output
  `MPS_ASSERT_IMP(a_in_stall_cause, !in_tready, out_tvalid && !out_tready, "input stalled with output free")

  `MPS_ASSERT_NXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata) && $stable(out_tlast), "result changed while stalled")

endmodule

bind max_pool_stream max_pool_stream_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
`default_nettype wire

// File: tb/max_pool_stream_test.sv
`timescale 1ns / 1ps
module max_pool_stream_test;
  import mps_pkg::*;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int HOLD_OFF_CYCLES = 200;

  typedef struct packed {
    logic [POOLED_W-1:0] pooled;
    logic [COL_W-1:0]    col;
    logic [COL_W-1:0]    row;
    logic [CHAN_W-1:0]   chan;
    logic                frame_end;
  } pooled_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wr_data;

  int send_idle_pct;
  int recv_stall_pct;
  int hold_request;
  int mismatch_count;
  int cycle_count;

  // model of the block: settings, raster position, per-column running maxima
  int unsigned win_side, map_cols, map_rows, map_chans;
  int unsigned at_col, at_row, at_chan, win_col, win_row;
  logic [POOLED_W-1:0] col_max [MAX_WIDTH];

  pooled_result_t pooled_expected [$];

  max_pool_stream dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("max_pool_stream_test: FAIL");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_request > 0) begin
      out_tready   <= 1'b0;
      hold_request <= hold_request - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic int unsigned clamp_setting(int unsigned raw, int unsigned hi);
    if (raw == 0) return 1;
    if (raw > hi) return hi;
    return raw;
  endfunction

  function automatic void restart_raster();
    at_col  = 0;
    at_row  = 0;
    at_chan = 0;
    win_col = 0;
    win_row = 0;
  endfunction

  function automatic void apply_setting(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_POOL_SIZE:     win_side  = clamp_setting(data[POOL_W-1:0], MAX_POOL);
      REG_IN_WIDTH:      map_cols  = clamp_setting(data[DIM_W-1:0], MAX_WIDTH);
      REG_IN_HEIGHT:     map_rows  = clamp_setting(data[DIM_W-1:0], MAX_WIDTH);
      REG_CHANNEL_COUNT: map_chans = clamp_setting(data[CHN_W-1:0], MAX_CHANNELS);
      default: ;
    endcase
    restart_raster();
  endfunction

  function automatic void predict_pooled(logic [IN_DATA_W-1:0] sample);
    logic [POOLED_W-1:0] level;
    int unsigned out_w, out_h, oc, orow;
    pooled_result_t res;
    level = sample[SAMPLE_BITS-1] ? '0 : sample[POOLED_W-1:0];
    out_w = map_cols / win_side;
    out_h = map_rows / win_side;
    oc    = at_col / win_side;
    orow  = at_row / win_side;
    if (oc < out_w && orow < out_h) begin
      if (win_row == 0 && win_col == 0) col_max[oc] = level;
      else if (level > col_max[oc]) col_max[oc] = level;
      if (win_row == win_side - 1 && win_col == win_side - 1) begin
        res.pooled    = col_max[oc];
        res.col       = oc[COL_W-1:0];
        res.row       = orow[COL_W-1:0];
        res.chan      = at_chan[CHAN_W-1:0];
        res.frame_end = (at_chan == map_chans - 1) && (orow == out_h - 1) &&
                        (oc == out_w - 1);
        pooled_expected.push_back(res);
      end
    end
    win_col++;
    if (win_col >= win_side) win_col = 0;
    at_col++;
    if (at_col >= map_cols) begin
      at_col  = 0;
      win_col = 0;
      win_row++;
      if (win_row >= win_side) win_row = 0;
      at_row++;
      if (at_row >= map_rows) begin
        at_row  = 0;
        win_row = 0;
        at_chan++;
        if (at_chan >= map_chans) at_chan = 0;
      end
    end
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : check_results
    pooled_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pooled_expected.size() == 0) begin
        $error("result: none expected, got pooled %0d col %0d row %0d channel %0d",
               out_tdata[POOLED_W-1:0], out_tdata[POOLED_W +: COL_W],
               out_tdata[POOLED_W+COL_W +: COL_W], out_tdata[POOLED_W+2*COL_W +: CHAN_W]);
        mismatch_count++;
      end else begin
        want = pooled_expected.pop_front();
        check_field("pooled", want.pooled, out_tdata[POOLED_W-1:0]);
        check_field("out_col", want.col, out_tdata[POOLED_W +: COL_W]);
        check_field("out_row", want.row, out_tdata[POOLED_W+COL_W +: COL_W]);
        check_field("out_channel", want.chan, out_tdata[POOLED_W+2*COL_W +: CHAN_W]);
        check_field("frame_end", want.frame_end, out_tlast);
      end
    end
  end

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic send_sample(logic [IN_DATA_W-1:0] sample);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= sample;
    do @(posedge clk); while (!in_tready);
    predict_pooled(sample);
  endtask

  task automatic wait_drained();
    while (pooled_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // bits above the register's width carry noise
  task automatic write_reg(cfg_reg_t idx, int unsigned value);
    logic [CFG_DATA_W-1:0] data;
    data = CFG_DATA_W'($urandom);
    case (idx)
      REG_POOL_SIZE: data[POOL_W-1:0] = value[POOL_W-1:0];
      REG_IN_WIDTH, REG_IN_HEIGHT: data[DIM_W-1:0] = value[DIM_W-1:0];
      default: data = value[CHN_W-1:0];
    endcase
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= data;
    @(posedge clk);
    apply_setting(idx, data);
  endtask

  task automatic configure(int unsigned pool, int unsigned cols, int unsigned rows,
                           int unsigned chans);
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait_drained();
    write_reg(REG_POOL_SIZE, pool);
    write_reg(REG_IN_WIDTH, cols);
    write_reg(REG_IN_HEIGHT, rows);
    write_reg(REG_CHANNEL_COUNT, chans);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic test_directed();
    set_idling(0, 0);
    // 2x2 windows, two channels: all-negative window, then ties at full scale
    configure(2, 2, 2, 2);
    send_sample(16'hFFFF);
    send_sample(16'h8000);
    send_sample(16'hFFFB);
    send_sample(16'hFFFE);
    send_sample(16'h7FFF);
    send_sample(16'h0000);
    send_sample(16'h0001);
    send_sample(16'h7FFF);
    // zero settings act as one: every sample is its own frame
    configure(0, 0, 0, 0);
    send_sample(16'h0100);
    send_sample(16'hFFFF);
    send_sample(16'h5555);
    // window wider than the map: nothing comes out
    configure(4, 3, 3, 1);
    repeat (9) send_sample(16'h2AAA);
  endtask

  task automatic test_backpressure();
    set_idling(0, 0);
    configure(1, 4, 4, 2);
    hold_request = HOLD_OFF_CYCLES;
    repeat (32) send_sample(IN_DATA_W'($urandom));
  endtask

  task automatic test_widest_row();
    set_idling(0, 60);
    configure(1, 300, 1, 1);
    repeat (256) send_sample(IN_DATA_W'($urandom));
  endtask

  task automatic test_tallest_column();
    set_idling(60, 0);
    configure(1, 1, 511, 1);
    repeat (256) send_sample(IN_DATA_W'($urandom));
  endtask

  task automatic test_most_channels();
    set_idling(38, 38);
    configure(1, 1, 1, 2047);
    repeat (1024) send_sample(IN_DATA_W'($urandom));
  endtask

  task automatic test_random_frames();
    int mode, sent, burst, frame_items;
    int unsigned pool, cols, rows, chans;
    for (mode = 0; mode < 4; mode++) begin
      case (mode)
        0: set_idling(0, 0);
        1: set_idling(60, 0);
        2: set_idling(0, 60);
        default: set_idling(38, 38);
      endcase
      sent = 0;
      while (sent < 100) begin
        if ($urandom_range(9) == 0) begin
          pool  = $urandom_range(8, 15);
          cols  = $urandom_range(8, 20);
          rows  = $urandom_range(8, 9);
          chans = 1;
        end else begin
          pool  = $urandom_range(0, 4);
          cols  = $urandom_range(0, 10);
          rows  = $urandom_range(0, 10);
          chans = $urandom_range(0, 3);
        end
        configure(pool, cols, rows, chans);
        frame_items = map_cols * map_rows * map_chans;
        if ($urandom_range(4) == 0) burst = $urandom_range(1, frame_items);
        else burst = frame_items * $urandom_range(1, 2);
        if (burst > 160) burst = 160;
        repeat (burst) send_sample(IN_DATA_W'($urandom));
        sent += burst;
      end
    end
  endtask

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    out_tready     = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_index      = REG_POOL_SIZE;
    cfg_wr_data    = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    win_side       = POOL_RESET;
    map_cols       = WIDTH_RESET;
    map_rows       = HEIGHT_RESET;
    map_chans      = CHAN_RESET;
    restart_raster();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_backpressure();
    test_widest_row();
    test_tallest_column();
    test_most_channels();
    test_random_frames();

    @(negedge clk);
    in_tvalid <= 1'b0;
    wait_drained();
    if (mismatch_count == 0) begin
      $display("max_pool_stream_test: PASS");
    end else begin
      $display("max_pool_stream_test: FAIL");
    end
    $finish;
  end

endmodule

// File: max_pool_stream.f
+incdir+rtl/core
rtl/core/mps_pkg.sv
rtl/core/mps_cfg.sv
rtl/core/mps_pos.sv
rtl/core/mps_pool.sv
rtl/core/max_pool_stream.sv
rtl/core/max_pool_stream_chk.sv
tb/max_pool_stream_test.sv
